// ===== rtl/core/lzss_pkg.sv =====
// ----------------------------------------------------------------------------
// lzss_pkg
// Shared types, codes and constants for the LZSS stream decoder.
// ----------------------------------------------------------------------------
package lzss_pkg;

   localparam int unsigned HISTORY_DEPTH_DEF = 4096;
   localparam int unsigned LEN_W             = 24;
   localparam int unsigned DIST_W            = 12;
   localparam int unsigned RUN_W             = 5;
   localparam int unsigned LEN_BIAS          = 2;
   localparam int unsigned GROUP_TOKENS      = 8;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_COPY_OOB = 2'd1,
      STATUS_LIT_PAST = 2'd2,
      STATUS_TRUNC    = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      OP_NONE      = 4'd0,
      OP_EMPTY_END = 4'd1,
      OP_TRUNC     = 4'd2,
      OP_CTRL      = 4'd3,
      OP_LIT       = 4'd4,
      OP_LIT_OVER  = 4'd5,
      OP_CW_LOW    = 4'd6,
      OP_CW_HIGH   = 4'd7,
      OP_COPY_RD   = 4'd8,
      OP_COPY_WR   = 4'd9,
      OP_COPY_FAIL = 4'd10
   } op_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic finished;
      logic exp_zero;
      logic phase_ctrl;
      logic phase_token;
      logic ctrl_bit;
      logic lit_over;
      logic copy_fail;
      logic copy_final;
      logic out_free;
   } stat_type;

endpackage

// ===== rtl/core/lzss_ctrl.sv =====
// ----------------------------------------------------------------------------
// lzss_ctrl
// Sequencer: decodes each accepted byte into a datapath operation and steps
// through copy runs, one history read and one write per copied byte.
// ----------------------------------------------------------------------------
module lzss_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic              req_tlast,
   input  lzss_pkg::stat_type stat,
   output lzss_pkg::cmd_type  cmd
);

   typedef enum logic [2:0] {
      ST_IDLE    = 3'b001,
      ST_COPY_RD = 3'b010,
      ST_COPY_WR = 3'b100
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd.op     = lzss_pkg::OP_NONE;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = stat.out_free;
            if (req_tvalid && stat.out_free) begin
               priority if (stat.finished) begin
                  cmd.op = lzss_pkg::OP_NONE;
               end else if (stat.exp_zero) begin
                  cmd.op = lzss_pkg::OP_EMPTY_END;
               end else if (stat.phase_ctrl) begin
                  cmd.op = req_tlast ? lzss_pkg::OP_TRUNC : lzss_pkg::OP_CTRL;
               end else if (stat.phase_token) begin
                  if (stat.ctrl_bit) begin
                     cmd.op = req_tlast ? lzss_pkg::OP_TRUNC : lzss_pkg::OP_CW_LOW;
                  end else begin
                     cmd.op = stat.lit_over ? lzss_pkg::OP_LIT_OVER : lzss_pkg::OP_LIT;
                  end
               end else begin
                  cmd.op   = lzss_pkg::OP_CW_HIGH;
                  state_in = ST_COPY_RD;
               end
            end
         end
         ST_COPY_RD: begin
            if (stat.copy_fail) begin
               if (stat.out_free) begin
                  cmd.op   = lzss_pkg::OP_COPY_FAIL;
                  state_in = ST_IDLE;
               end
            end else begin
               cmd.op   = lzss_pkg::OP_COPY_RD;
               state_in = ST_COPY_WR;
            end
         end
         ST_COPY_WR: begin
            if (stat.out_free) begin
               cmd.op   = lzss_pkg::OP_COPY_WR;
               state_in = stat.copy_final ? ST_IDLE : ST_COPY_RD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ===== rtl/core/lzss_datapath.sv =====
// ----------------------------------------------------------------------------
// lzss_datapath
// Parse registers, output counter, history memory and result register.
// ----------------------------------------------------------------------------
module lzss_datapath #(
   parameter int unsigned HISTORY_DEPTH = lzss_pkg::HISTORY_DEPTH_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_wr_en,
   input  logic [lzss_pkg::LEN_W-1:0] csr_wr_data,
   input  logic [7:0]                req_tdata,
   input  logic                      req_tlast,
   input  lzss_pkg::cmd_type          cmd,
   output lzss_pkg::stat_type         stat,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [15:0]               rsp_tdata,
   output logic [0:0]                rsp_tuser,
   output logic                      rsp_tlast
);

   localparam int unsigned AW = $clog2(HISTORY_DEPTH);

   typedef enum logic [2:0] {
      PH_CONTROL   = 3'b001,
      PH_TOKEN     = 3'b010,
      PH_CODE_HIGH = 3'b100
   } phase_type;

   logic [lzss_pkg::LEN_W-1:0]  expected_ff, expected_in;
   logic [7:0]                  ctrl_bits_ff, ctrl_bits_in;
   logic [3:0]                  tokens_ff, tokens_in;
   phase_type                   phase_ff, phase_in;
   logic [7:0]                  code_low_ff, code_low_in;
   logic [lzss_pkg::LEN_W-1:0]  pc_ff, pc_in;
   logic                        finished_ff, finished_in;
   logic [lzss_pkg::DIST_W-1:0] dist_ff, dist_in;
   logic [lzss_pkg::RUN_W-1:0]  remain_ff, remain_in;
   logic                        cw_last_ff, cw_last_in;

   logic                        out_valid_ff, out_valid_in;
   logic [7:0]                  out_byte_ff, out_byte_in;
   logic                        byte_valid_ff, byte_valid_in;
   logic                        run_last_ff, run_last_in;
   logic                        stream_end_ff, stream_end_in;
   lzss_pkg::status_type        status_ff, status_in;

   logic [7:0]                  hist_mem [HISTORY_DEPTH];
   logic [7:0]                  rd_data_ff;
   logic                        wr_en;
   logic [7:0]                  wr_data;
   logic                        rd_en;
   logic [AW-1:0]               rd_addr;

   logic                        out_free;
   logic                        load;
   logic [7:0]                  copy_byte;
   logic [3:0]                  tokens_next;
   logic                        token_done;
   logic                        token_last;

   assign out_free    = !out_valid_ff || rsp_tready;
   assign copy_byte   = (dist_ff == '0) ? 8'd0 : rd_data_ff;
   assign tokens_next = tokens_ff + 4'd1;
   assign rd_addr     = pc_ff[AW-1:0] - AW'(dist_ff);

   assign stat.finished    = finished_ff;
   assign stat.exp_zero    = (expected_ff == '0);
   assign stat.phase_ctrl  = (phase_ff == PH_CONTROL);
   assign stat.phase_token = (phase_ff == PH_TOKEN);
   assign stat.ctrl_bit    = ctrl_bits_ff[0];
   assign stat.lit_over    = (pc_ff >= expected_ff);
   assign stat.copy_fail   = (pc_ff < lzss_pkg::LEN_W'(dist_ff)) || (pc_ff >= expected_ff);
   assign stat.copy_final  = (remain_ff == lzss_pkg::RUN_W'(1));
   assign stat.out_free    = out_free;

   always_comb begin
      expected_in   = csr_wr_en ? csr_wr_data : expected_ff;
      ctrl_bits_in  = ctrl_bits_ff;
      tokens_in     = tokens_ff;
      phase_in      = phase_ff;
      code_low_in   = code_low_ff;
      pc_in         = pc_ff;
      finished_in   = finished_ff;
      dist_in       = dist_ff;
      remain_in     = remain_ff;
      cw_last_in    = cw_last_ff;
      out_byte_in   = out_byte_ff;
      byte_valid_in = byte_valid_ff;
      run_last_in   = run_last_ff;
      stream_end_in = stream_end_ff;
      status_in     = status_ff;
      load          = 1'b0;
      wr_en         = 1'b0;
      wr_data       = req_tdata;
      rd_en         = 1'b0;
      token_done    = 1'b0;
      token_last    = 1'b0;

      unique case (cmd.op)
         lzss_pkg::OP_NONE: begin
         end
         lzss_pkg::OP_EMPTY_END: begin
            load          = 1'b1;
            out_byte_in   = 8'd0;
            byte_valid_in = 1'b0;
            run_last_in   = 1'b1;
            stream_end_in = 1'b1;
            status_in     = lzss_pkg::STATUS_OK;
            finished_in   = 1'b1;
         end
         lzss_pkg::OP_TRUNC: begin
            load          = 1'b1;
            out_byte_in   = 8'd0;
            byte_valid_in = 1'b0;
            run_last_in   = 1'b1;
            stream_end_in = 1'b1;
            status_in     = lzss_pkg::STATUS_TRUNC;
            finished_in   = 1'b1;
         end
         lzss_pkg::OP_CTRL: begin
            ctrl_bits_in = req_tdata;
            tokens_in    = 4'd0;
            phase_in     = PH_TOKEN;
         end
         lzss_pkg::OP_LIT: begin
            load          = 1'b1;
            wr_en         = 1'b1;
            wr_data       = req_tdata;
            pc_in         = pc_ff + lzss_pkg::LEN_W'(1);
            out_byte_in   = req_tdata;
            byte_valid_in = 1'b1;
            run_last_in   = 1'b1;
            stream_end_in = req_tlast;
            status_in     = lzss_pkg::STATUS_OK;
            token_done    = 1'b1;
            token_last    = req_tlast;
         end
         lzss_pkg::OP_LIT_OVER: begin
            load          = 1'b1;
            out_byte_in   = 8'd0;
            byte_valid_in = 1'b0;
            run_last_in   = 1'b1;
            stream_end_in = 1'b1;
            status_in     = lzss_pkg::STATUS_LIT_PAST;
            finished_in   = 1'b1;
         end
         lzss_pkg::OP_CW_LOW: begin
            code_low_in = req_tdata;
            phase_in    = PH_CODE_HIGH;
         end
         lzss_pkg::OP_CW_HIGH: begin
            dist_in    = {req_tdata[3:0], code_low_ff};
            remain_in  = lzss_pkg::RUN_W'(req_tdata[7:4]) + lzss_pkg::RUN_W'(lzss_pkg::LEN_BIAS);
            cw_last_in = req_tlast;
         end
         lzss_pkg::OP_COPY_RD: begin
            rd_en = 1'b1;
         end
         lzss_pkg::OP_COPY_WR: begin
            load          = 1'b1;
            wr_en         = 1'b1;
            wr_data       = copy_byte;
            pc_in         = pc_ff + lzss_pkg::LEN_W'(1);
            remain_in     = remain_ff - lzss_pkg::RUN_W'(1);
            out_byte_in   = copy_byte;
            byte_valid_in = 1'b1;
            run_last_in   = stat.copy_final;
            stream_end_in = stat.copy_final && cw_last_ff;
            status_in     = lzss_pkg::STATUS_OK;
            token_done    = stat.copy_final;
            token_last    = cw_last_ff;
         end
         lzss_pkg::OP_COPY_FAIL: begin
            load          = 1'b1;
            out_byte_in   = 8'd0;
            byte_valid_in = 1'b0;
            run_last_in   = 1'b1;
            stream_end_in = 1'b1;
            status_in     = lzss_pkg::STATUS_COPY_OOB;
            finished_in   = 1'b1;
         end
         default: begin
         end
      endcase

      if (token_done) begin
         ctrl_bits_in = {1'b0, ctrl_bits_ff[7:1]};
         tokens_in    = tokens_next;
         if (token_last) begin
            finished_in = 1'b1;
         end else if (tokens_next >= 4'(lzss_pkg::GROUP_TOKENS)) begin
            tokens_in = 4'd0;
            phase_in  = PH_CONTROL;
         end else begin
            phase_in = PH_TOKEN;
         end
      end

      out_valid_in = load ? 1'b1 : (out_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         expected_ff  <= '0;
         ctrl_bits_ff <= '0;
         tokens_ff    <= '0;
         phase_ff     <= PH_CONTROL;
         code_low_ff  <= '0;
         pc_ff        <= '0;
         finished_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         expected_ff  <= expected_in;
         ctrl_bits_ff <= ctrl_bits_in;
         tokens_ff    <= tokens_in;
         phase_ff     <= phase_in;
         code_low_ff  <= code_low_in;
         pc_ff        <= pc_in;
         finished_ff  <= finished_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dist_ff       <= dist_in;
      remain_ff     <= remain_in;
      cw_last_ff    <= cw_last_in;
      out_byte_ff   <= out_byte_in;
      byte_valid_ff <= byte_valid_in;
      run_last_ff   <= run_last_in;
      stream_end_ff <= stream_end_in;
      status_ff     <= status_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         hist_mem[pc_ff[AW-1:0]] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= hist_mem[rd_addr];
      end
   end

   assign rsp_tvalid   = out_valid_ff;
   assign rsp_tdata    = {5'd0, status_ff, stream_end_ff, out_byte_ff};
   assign rsp_tuser[0] = byte_valid_ff;
   assign rsp_tlast    = run_last_ff;

`ifndef SYNTHESIS
   a_finished_sticky: assert property (@(posedge clock) disable iff (reset)
      finished_ff |=> finished_ff)
      else $error("finished flag dropped without reset");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      load |-> out_free)
      else $error("result register loaded while a beat is pending");

   a_copy_count: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == lzss_pkg::OP_COPY_WR) |-> (remain_ff != '0))
      else $error("copy write with no bytes left in run");

   a_group_bound: assert property (@(posedge clock) disable iff (reset)
      !finished_ff |-> (tokens_ff < 4'(lzss_pkg::GROUP_TOKENS)))
      else $error("token count exceeds group size");

   a_no_result_after_end: assert property (@(posedge clock) disable iff (reset)
      finished_ff |-> !load)
      else $error("result produced after stream end");
`endif

endmodule

// ===== rtl/core/lzss_stream_decoder.sv =====
// ----------------------------------------------------------------------------
// lzss_stream_decoder
// LZSS decoder, 12-bit distance and 4-bit length, with a byte history.
// ----------------------------------------------------------------------------
//  channel  dir  beat payload
//  req      in   tdata[7:0] compressed byte, tlast final byte of stream
//  rsp      out  tdata[7:0] byte, [8] stream end, [10:9] status;
//                tuser[0] byte valid, tlast last beat of its input byte
//  csr      in   csr_wr_data[23:0] expected output length
//
//  Control, codeword-low and literal bytes are each handled as they are accepted;
//  a codeword-high byte starts the copy run, and each copied byte takes
//  a registered history read, then the write and result beat.
//  Synchronous reset clears control state; the history needs no clearing.
//  A stalled result beat holds input acceptance and copy progress.
// ----------------------------------------------------------------------------
module lzss_stream_decoder #(
   parameter int unsigned HISTORY_DEPTH = lzss_pkg::HISTORY_DEPTH_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_wr_en,
   input  logic [lzss_pkg::LEN_W-1:0] csr_wr_data,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [7:0]                 req_tdata,   // [7:0] in_byte
   input  logic                       req_tlast,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [15:0]                rsp_tdata,   // [7:0] out_byte, [8] stream_end,
                                                   // [10:9] status
   output logic [0:0]                 rsp_tuser,   // [0] byte_valid
   output logic                       rsp_tlast
);

   lzss_pkg::cmd_type  cmd;
   lzss_pkg::stat_type stat;

   lzss_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tlast  (req_tlast),
      .stat       (stat),
      .cmd        (cmd)
   );

   lzss_datapath #(
      .HISTORY_DEPTH (HISTORY_DEPTH)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .cmd         (cmd),
      .stat        (stat),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast)
   );

endmodule
